// ===== sv/dwcp_pkg.sv =====
// Shared types and constants for the delimited word code packer.
// No dependencies; imported by delimited_word_code_packer.
package dwcp_pkg;

    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 64;
    localparam int WORD_CNT_W  = 4;
    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd32;

    // One result transfer as held in the output register
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              code_valid;
        logic              end_of_command;
    } result_t;

endpackage

// ===== sv/delimited_word_code_packer.sv =====
// Delimited word code packer: splits a byte stream into words and packs each
// word big-endian into a 64-bit code. Depends on dwcp_pkg.
//
//  channel | dir | handshake               | payload
//  s_*     | in  | s_tvalid / s_tready     | s_tdata = text_byte, s_tlast = final_byte
//  m_*     | out | m_tvalid / m_tready     | m_tdata = word_code, m_tuser = code_valid,
//          |     |                         | m_tlast = end_of_command
//  cfg_*   | in  | cfg_we                  | cfg_data = delimiter
//
// One byte is accepted every cycle while the output is not stalled; a byte's
// result passes from the input register through the word state update into the result register.
// Reset clears both stages and the word state; delimiter returns to 32.
// An output stall holds the result register and, once the input register is
// full, drops s_tready in the same cycle.
module delimited_word_code_packer #(
    parameter int MAX_TOKENS     = 8,
    parameter int BYTES_PER_CODE = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dwcp_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] text_byte
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dwcp_pkg::CODE_W-1:0]  m_tdata,   // [63:0] word_code
    output logic [0:0]                   m_tuser,   // [0] code_valid
    output logic                         m_tlast,
    input  logic                         cfg_we,
    input  logic [dwcp_pkg::BYTE_W-1:0]  cfg_data
);
    import dwcp_pkg::*;

    localparam int CNT_W     = $clog2(BYTES_PER_CODE + 1);
    localparam int TOP_SHIFT = (BYTES_PER_CODE - 1) * 8;

    // Input stage
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Word state
    logic [BYTE_W-1:0]     delim_reg;
    logic [CODE_W-1:0]     pending_reg, pending_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [WORD_CNT_W-1:0] words_reg, words_next;
    logic                  inside_reg, inside_next;

    // Result stage
    logic    out_valid_reg;
    result_t out_reg, out_next;
    logic    produce;

    logic advance;
    logic proc;
    logic limit_hit;
    logic is_delim;
    logic emit_word;
    logic [5:0] byte_shift;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign proc     = in_valid_reg && advance;

    // Update word state for the byte in the input register
    always_comb
    begin
        limit_hit  = words_reg >= WORD_CNT_W'(MAX_TOKENS);
        is_delim   = in_byte_reg == delim_reg;
        emit_word  = !limit_hit && is_delim && inside_reg;
        byte_shift = 6'(TOP_SHIFT) - 6'({count_reg, 3'b000});

        pending_next = pending_reg;
        count_next   = count_reg;
        words_next   = words_reg;
        inside_next  = inside_reg;

        if (!limit_hit)
        begin
            if (is_delim)
            begin
                if (inside_reg)
                begin
                    words_next   = words_reg + 1'b1;
                    pending_next = '0;
                    count_next   = '0;
                    inside_next  = 1'b0;
                end
            end
            else
            begin
                if (count_reg < CNT_W'(BYTES_PER_CODE))
                begin
                    pending_next = pending_reg
                                 | (CODE_W'(in_byte_reg) << byte_shift);
                    count_next   = count_reg + 1'b1;
                end
                inside_next = 1'b1;
            end
        end

        // Build the result: word on delimiter, else on the final byte the pending word or terminator
        produce = emit_word || in_last_reg;
        if (emit_word)
        begin
            out_next.code           = pending_reg;
            out_next.code_valid     = 1'b1;
            out_next.end_of_command = in_last_reg;
        end
        else
        begin
            out_next.code           = inside_next ? pending_next : '0;
            out_next.code_valid     = inside_next;
            out_next.end_of_command = 1'b1;
        end
    end

    // Hold the delimiter register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delim_reg <= DELIM_RESET;
        else if (cfg_we)
            delim_reg <= cfg_data;
    end

    // Load the input register on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Advance word state; clear it after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            count_reg   <= '0;
            words_reg   <= '0;
            inside_reg  <= 1'b0;
        end
        else if (proc)
        begin
            if (in_last_reg)
            begin
                pending_reg <= '0;
                count_reg   <= '0;
                words_reg   <= '0;
                inside_reg  <= 1'b0;
            end
            else
            begin
                pending_reg <= pending_next;
                count_reg   <= count_next;
                words_reg   <= words_next;
                inside_reg  <= inside_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= proc && produce;
    end

    always_ff @(posedge clk)
    begin
        if (proc && produce)
            out_reg <= out_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.code;
    assign m_tuser[0] = out_reg.code_valid;
    assign m_tlast    = out_reg.end_of_command;

    // A terminator only closes a string and carries a zero code
    a_term_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == '0))
        else $error("terminator without end_of_command or with nonzero code");

    // Word count never passes the limit
    a_words_bound: assert property (@(posedge clk) disable iff (!rst_n)
        words_reg <= WORD_CNT_W'(MAX_TOKENS))
        else $error("word count beyond limit");

    // Byte count saturates
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BYTES_PER_CODE))
        else $error("byte count beyond code width");

    // Final byte returns word state to its idle value
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_last_reg |=> words_reg == '0 && !inside_reg && pending_reg == '0)
        else $error("word state not cleared after final byte");

    // Final byte always yields a result
    a_last_yields: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_last_reg |=> m_tvalid && m_tlast)
        else $error("final byte produced no result");

endmodule
